### src/cwu_pkg.sv
// ----------------------------------------------------------------------------
// cwu_pkg
// Shared types and constants for the congestion window update block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cwu_pkg;

	localparam int unsigned SEG_W   = 16;
	localparam int unsigned BYTES_W = 32;
	localparam int unsigned OP_W    = 2;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 32;
	localparam int unsigned CREDIT_W = BYTES_W + 1;
	localparam int unsigned DIV_W   = BYTES_W - 1;
	localparam int unsigned PROD_W  = BYTES_W + SEG_W;

	// event codes
	localparam logic [OP_W-1:0] OP_ACK     = 2'd0;
	localparam logic [OP_W-1:0] OP_LOSS    = 2'd1;
	localparam logic [OP_W-1:0] OP_TIMEOUT = 2'd2;
	localparam logic [OP_W-1:0] OP_RESTART = 2'd3;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SEGMENT_SIZE      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LIMIT      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PROTOCOL_MODE     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_INITIAL_WINDOW    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_INITIAL_THRESHOLD = 3'd4;

	// register reset values
	localparam logic [SEG_W-1:0]   RST_SEGMENT_SIZE      = 16'd1460;
	localparam logic [BYTES_W-1:0] RST_WINDOW_LIMIT      = 32'd1048576;
	localparam logic               RST_PROTOCOL_MODE     = 1'b0;
	localparam logic [BYTES_W-1:0] RST_INITIAL_WINDOW    = 32'd4380;
	localparam logic [BYTES_W-1:0] RST_INITIAL_THRESHOLD = 32'd65535;

	localparam logic [BYTES_W-1:0] MIN_SEGMENTS = 32'd2;

	typedef struct packed {
		logic [OP_W-1:0]    operation;
		logic [BYTES_W-1:0] bytes_acked;
		logic [BYTES_W-1:0] flight_size;
		logic [SEG_W-1:0]   dupack_count;
	} cwu_req_t;

	typedef struct packed {
		logic [BYTES_W-1:0] window;
		logic [BYTES_W-1:0] threshold;
	} cwu_res_t;

endpackage

`default_nettype wire

### src/congestion_window_update.sv
// ----------------------------------------------------------------------------
// congestion_window_update
// NewReno style congestion window and slow-start threshold keeper. Each
// request (ack, loss, retransmit timeout or restart) returns one response
// with the window and threshold after the event. Ack and restart requests
// are handled without the divider; loss and timeout requests first pass a
// restoring divider that retires one quotient bit per cycle over 31 bits,
// followed by one or two passes through a shared 32x16 multiplier. The
// block takes one request at a time; a finished response waits in an output
// register while the next request is accepted.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module congestion_window_update import cwu_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  req_valid,
	output logic                       req_ready,
	input  wire cwu_req_t              req_data,
	output logic                       res_valid,
	input  wire logic                  res_ready,
	output cwu_res_t                   res_data,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_ACK   = 3'd1;
	localparam logic [2:0] ST_DIV   = 3'd2;
	localparam logic [2:0] ST_MUL_T = 3'd3;
	localparam logic [2:0] ST_MUL_W = 3'd4;
	localparam logic [2:0] ST_DONE  = 3'd5;

	localparam logic [4:0] DIV_LAST = 5'(DIV_W - 1);

	logic [SEG_W-1:0]   segment_size_q;
	logic [BYTES_W-1:0] window_limit_q;
	logic               protocol_mode_q;
	logic [BYTES_W-1:0] initial_window_q;
	logic [BYTES_W-1:0] initial_threshold_q;

	logic [BYTES_W-1:0]  cwnd_q;
	logic [BYTES_W-1:0]  ssthresh_q;
	logic [CREDIT_W-1:0] credit_q;

	logic [2:0]         state_q;
	cwu_req_t           req_q;
	logic [DIV_W-1:0]   div_q;
	logic [SEG_W-1:0]   rem_q;
	logic [4:0]         count_q;

	// divider step
	logic [SEG_W:0]     trial;
	logic               trial_ge;
	logic [SEG_W:0]     trial_sub;

	// ack arithmetic
	logic               slow_start;
	logic               credit_pos;
	logic [BYTES_W-1:0] ack_step;
	logic [BYTES_W-1:0] addend;
	logic [BYTES_W:0]   grow_sum;
	logic [BYTES_W-1:0] grow_capped;
	logic [CREDIT_W-1:0] credit_dec;

	// shared multiplier
	logic [BYTES_W-1:0] mul_a;
	logic [PROD_W-1:0]  prod;
	logic [BYTES_W-1:0] prod_sat;

	assign req_ready = (state_q == ST_IDLE);

	always_comb begin
		trial     = {rem_q, div_q[DIV_W-1]};
		trial_ge  = (trial >= {1'b0, segment_size_q});
		trial_sub = trial - {1'b0, segment_size_q};
	end

	always_comb begin
		slow_start = (cwnd_q < ssthresh_q);
		credit_pos = !credit_q[CREDIT_W-1] && (credit_q != '0);
		ack_step   = {{(BYTES_W-SEG_W){1'b0}}, segment_size_q};
		if (protocol_mode_q && (req_q.bytes_acked < ack_step)) begin
			ack_step = req_q.bytes_acked;
		end
		addend      = slow_start ? ack_step : {{(BYTES_W-SEG_W){1'b0}}, segment_size_q};
		grow_sum    = {1'b0, cwnd_q} + {1'b0, addend};
		grow_capped = (grow_sum > {1'b0, window_limit_q}) ? window_limit_q
			: grow_sum[BYTES_W-1:0];
		credit_dec  = credit_q - (protocol_mode_q ? {1'b0, req_q.bytes_acked}
			: {{(CREDIT_W-SEG_W){1'b0}}, segment_size_q});
	end

	always_comb begin
		if (state_q == ST_MUL_T) begin
			mul_a = ({1'b0, div_q} < MIN_SEGMENTS) ? MIN_SEGMENTS : {1'b0, div_q};
		end else begin
			mul_a = {1'b0, div_q} + {{(BYTES_W-SEG_W){1'b0}}, req_q.dupack_count};
		end
		prod     = {{SEG_W{1'b0}}, mul_a} * {{BYTES_W{1'b0}}, segment_size_q};
		prod_sat = (|prod[PROD_W-1:BYTES_W]) ? '1 : prod[BYTES_W-1:0];
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			segment_size_q      <= RST_SEGMENT_SIZE;
			window_limit_q      <= RST_WINDOW_LIMIT;
			protocol_mode_q     <= RST_PROTOCOL_MODE;
			initial_window_q    <= RST_INITIAL_WINDOW;
			initial_threshold_q <= RST_INITIAL_THRESHOLD;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SEGMENT_SIZE:      segment_size_q      <= cfg_wdata[SEG_W-1:0];
				REG_WINDOW_LIMIT:      window_limit_q      <= cfg_wdata[BYTES_W-1:0];
				REG_PROTOCOL_MODE:     protocol_mode_q     <= cfg_wdata[0];
				REG_INITIAL_WINDOW:    initial_window_q    <= cfg_wdata[BYTES_W-1:0];
				REG_INITIAL_THRESHOLD: initial_threshold_q <= cfg_wdata[BYTES_W-1:0];
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					req_q   <= req_data;
					rem_q   <= '0;
					count_q <= '0;
					div_q   <= protocol_mode_q ? cwnd_q[BYTES_W-1:1]
						: req_data.flight_size[BYTES_W-1:1];
				end
			end
			ST_DIV: begin
				rem_q   <= trial_ge ? trial_sub[SEG_W-1:0] : trial[SEG_W-1:0];
				div_q   <= {div_q[DIV_W-2:0], trial_ge};
				count_q <= count_q + 5'd1;
			end
			default: ;
		endcase
	end

	// sequencer and connection state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cwnd_q     <= RST_INITIAL_WINDOW;
			ssthresh_q <= RST_INITIAL_THRESHOLD;
			credit_q   <= '0;
			res_valid  <= 1'b0;
			res_data   <= '0;
		end else begin
			if ((state_q == ST_DONE) && (!res_valid || res_ready)) begin
				res_valid <= 1'b1;
			end else if (res_valid && res_ready) begin
				res_valid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						case (req_data.operation)
							OP_ACK: state_q <= ST_ACK;
							OP_RESTART: begin
								cwnd_q     <= initial_window_q;
								ssthresh_q <= initial_threshold_q;
								credit_q   <= '0;
								state_q    <= ST_DONE;
							end
							default: state_q <= ST_DIV;
						endcase
					end
				end
				ST_ACK: begin
					if (slow_start) begin
						cwnd_q <= grow_capped;
					end else if (credit_pos) begin
						credit_q <= credit_dec;
					end else begin
						cwnd_q   <= grow_capped;
						credit_q <= {1'b0, grow_capped};
					end
					state_q <= ST_DONE;
				end
				ST_DIV: begin
					if (count_q == DIV_LAST) begin
						state_q <= ST_MUL_T;
					end
				end
				ST_MUL_T: begin
					ssthresh_q <= prod_sat;
					credit_q   <= '0;
					if (req_q.operation == OP_LOSS) begin
						state_q <= ST_MUL_W;
					end else begin
						cwnd_q  <= {{(BYTES_W-SEG_W){1'b0}}, segment_size_q};
						state_q <= ST_DONE;
					end
				end
				ST_MUL_W: begin
					cwnd_q  <= protocol_mode_q ? ssthresh_q : prod_sat;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!res_valid || res_ready) begin
						res_data.window    <= cwnd_q;
						res_data.threshold <= ssthresh_q;
						state_q            <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

### sim/tb_congestion_window_update.sv
// ----------------------------------------------------------------------------
// tb_congestion_window_update
// Self-checking bench for the congestion window update block. A behavioral
// copy of the window, threshold and credit state predicts each response;
// directed requests cover field extremes, both protocol modes, saturation and
// zero sizes, then random traffic runs under many register settings with
// bursty requests and a stalling response side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_congestion_window_update;

	import cwu_pkg::*;

	localparam int unsigned SETTLE_CYCLES   = 40;
	localparam int unsigned STALL_LIMIT     = 3000;
	localparam int unsigned RANDOM_PHASES   = 10;
	localparam int unsigned ITEMS_PER_PHASE = 85;

	// indexes past the register list
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd6;

	typedef enum logic [1:0] {RX_STEADY, RX_COIN, RX_PERIODIC, RX_SPARSE} rx_pattern_t;

	logic                  clk;
	logic                  arst_n    = 1'b0;
	logic                  req_valid = 1'b0;
	logic                  req_ready;
	cwu_req_t              req_data  = '0;
	logic                  res_valid;
	logic                  res_ready = 1'b0;
	cwu_res_t              res_data;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	// predicted block state and register copies
	logic [SEG_W-1:0]          seg_size;
	logic [BYTES_W-1:0]        win_limit;
	logic                      sctp_mode;
	logic [BYTES_W-1:0]        init_win;
	logic [BYTES_W-1:0]        init_thr;
	logic [BYTES_W-1:0]        cwnd_now;
	logic [BYTES_W-1:0]        ssthresh_now;
	logic signed [CREDIT_W-1:0] credit_now;

	cwu_res_t    pending_windows[$];
	cwu_res_t    expected_res;
	int unsigned op_seen[4];
	int unsigned responses_checked;
	int unsigned mismatches;
	int unsigned settings_applied;

	rx_pattern_t rx_pattern  = RX_STEADY;
	logic [5:0]  stall_phase = '0;

	congestion_window_update u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_data  (req_data),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_data  (res_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	function automatic logic [BYTES_W-1:0] saturate(input logic [63:0] v);
		return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[BYTES_W-1:0];
	endfunction

	function automatic logic [BYTES_W-1:0] cap_to_limit(input logic [63:0] v);
		return (v > {32'd0, win_limit}) ? win_limit : v[BYTES_W-1:0];
	endfunction

	function automatic cwu_res_t advance_window(input cwu_req_t rq);
		logic [BYTES_W-1:0] halved_src;
		logic [BYTES_W-1:0] segs;
		logic [BYTES_W-1:0] step;
		logic [BYTES_W-1:0] floor_thr;
		logic [63:0]        wide;
		cwu_res_t           res;
		halved_src = sctp_mode ? cwnd_now : rq.flight_size;
		if (seg_size == '0) segs = '0;
		else segs = (halved_src >> 1) / seg_size;
		wide = {32'd0, (segs < MIN_SEGMENTS) ? MIN_SEGMENTS : segs} * seg_size;
		floor_thr = saturate(wide);
		case (rq.operation)
		OP_ACK: begin
			if (cwnd_now >= ssthresh_now) begin
				if (credit_now > 0) begin
					if (sctp_mode) credit_now = credit_now - $signed({1'b0, rq.bytes_acked});
					else credit_now = credit_now - $signed({17'd0, seg_size});
				end else begin
					cwnd_now = cap_to_limit({32'd0, cwnd_now} + seg_size);
					credit_now = $signed({1'b0, cwnd_now});
				end
			end else begin
				step = {16'd0, seg_size};
				if (sctp_mode && rq.bytes_acked < step) step = rq.bytes_acked;
				cwnd_now = cap_to_limit({32'd0, cwnd_now} + step);
			end
		end
		OP_LOSS: begin
			ssthresh_now = floor_thr;
			if (sctp_mode) cwnd_now = floor_thr;
			else cwnd_now = saturate(({32'd0, segs} + rq.dupack_count) * seg_size);
			credit_now = '0;
		end
		OP_TIMEOUT: begin
			ssthresh_now = floor_thr;
			cwnd_now = {16'd0, seg_size};
			credit_now = '0;
		end
		default: begin
			cwnd_now = init_win;
			ssthresh_now = init_thr;
			credit_now = '0;
		end
		endcase
		res.window = cwnd_now;
		res.threshold = ssthresh_now;
		return res;
	endfunction

	task automatic send_event(input logic [OP_W-1:0] op, input logic [BYTES_W-1:0] acked,
			input logic [BYTES_W-1:0] flight, input logic [SEG_W-1:0] dups);
		cwu_req_t rq;
		rq.operation = op;
		rq.bytes_acked = acked;
		rq.flight_size = flight;
		rq.dupack_count = dups;
		req_data <= rq;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_ready !== 1'b1) @(posedge clk);
		pending_windows.push_back(advance_window(rq));
		op_seen[op]++;
	endtask

	task automatic pause_requests(input int unsigned cycles);
		req_valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	task automatic wait_drained();
		req_valid <= 1'b0;
		while (pending_windows.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
		REG_SEGMENT_SIZE:      seg_size = val[SEG_W-1:0];
		REG_WINDOW_LIMIT:      win_limit = val;
		REG_PROTOCOL_MODE:     sctp_mode = val[0];
		REG_INITIAL_WINDOW:    init_win = val;
		REG_INITIAL_THRESHOLD: init_thr = val;
		default: ;
		endcase
	endtask

	task automatic apply_settings(input logic [SEG_W-1:0] seg, input logic [BYTES_W-1:0] limit,
			input logic mode, input logic [BYTES_W-1:0] iw, input logic [BYTES_W-1:0] ith);
		wait_drained();
		write_register(REG_SEGMENT_SIZE, {16'd0, seg});
		write_register(REG_WINDOW_LIMIT, limit);
		write_register(REG_PROTOCOL_MODE, {31'd0, mode});
		write_register(REG_INITIAL_WINDOW, iw);
		write_register(REG_INITIAL_THRESHOLD, ith);
		settings_applied++;
	endtask

	task automatic test_reset_values();
		send_event(OP_ACK, 32'd0, 32'd0, 16'd0);
		send_event(OP_LOSS, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
		send_event(OP_TIMEOUT, 32'd0, 32'd0, 16'd0);
		send_event(OP_RESTART, 32'd0, 32'd0, 16'd0);
	endtask

	task automatic test_tcp_extremes();
		apply_settings(16'hFFFF, 32'hFFFF_FFFF, 1'b0, RST_INITIAL_WINDOW, RST_INITIAL_THRESHOLD);
		// window product overflows and saturates
		send_event(OP_LOSS, 32'd0, 32'hFFFF_FFFF, 16'hFFFF);
		send_event(OP_ACK, 32'hFFFF_FFFF, 32'd0, 16'd0);
		send_event(OP_ACK, 32'd0, 32'd0, 16'd0);
	endtask

	task automatic test_sctp_steps();
		apply_settings(16'd1460, RST_WINDOW_LIMIT, 1'b1, RST_INITIAL_WINDOW,
			RST_INITIAL_THRESHOLD);
		send_event(OP_RESTART, 32'd0, 32'd0, 16'd0);
		send_event(OP_ACK, 32'd0, 32'd0, 16'd0);
		send_event(OP_ACK, 32'd100, 32'd0, 16'd0);
		send_event(OP_ACK, 32'hFFFF_FFFF, 32'd0, 16'd0);
		send_event(OP_LOSS, 32'd0, 32'hFFFF_FFFF, 16'hFFFF);
		send_event(OP_TIMEOUT, 32'd0, 32'hFFFF_FFFF, 16'd0);
		// start in avoidance and drive the credit negative
		apply_settings(16'd1460, RST_WINDOW_LIMIT, 1'b1, 32'd2000, 32'd1000);
		send_event(OP_RESTART, 32'd0, 32'd0, 16'd0);
		send_event(OP_ACK, 32'd1, 32'd0, 16'd0);
		send_event(OP_ACK, 32'd1, 32'd0, 16'd0);
		send_event(OP_ACK, 32'hFFFF_FFFF, 32'd0, 16'd0);
		send_event(OP_ACK, 32'd0, 32'd0, 16'd0);
	endtask

	task automatic test_zero_sizes();
		apply_settings(16'd0, 32'd0, 1'b0, RST_INITIAL_WINDOW, RST_INITIAL_THRESHOLD);
		// writes past the register list are dropped
		write_register(REG_SPARE_A, 32'hFFFF_FFFF);
		write_register(REG_SPARE_B, 32'd1);
		send_event(OP_RESTART, 32'd0, 32'd0, 16'd0);
		send_event(OP_ACK, 32'hFFFF_FFFF, 32'd0, 16'd0);
		send_event(OP_LOSS, 32'd0, 32'hFFFF_FFFF, 16'hFFFF);
		send_event(OP_TIMEOUT, 32'd0, 32'hFFFF_FFFF, 16'd0);
	endtask

	task automatic test_random_traffic();
		int unsigned        phase;
		int unsigned        n;
		int unsigned        pick;
		int unsigned        burst_left;
		logic [SEG_W-1:0]   seg;
		logic [BYTES_W-1:0] limit;
		logic [BYTES_W-1:0] iw;
		logic [BYTES_W-1:0] ith;
		logic [OP_W-1:0]    op;
		logic [BYTES_W-1:0] acked;
		logic [BYTES_W-1:0] flight;
		logic [SEG_W-1:0]   dups;
		burst_left = 0;
		for (phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase)
			0: begin
				seg = 16'd1;
				limit = 32'hFFFF_FFFF;
				iw = 32'd1;
				ith = 32'd200;
			end
			1: begin
				seg = 16'hFFFF;
				limit = 32'd1;
				iw = 32'hFFFF_FFFF;
				ith = 32'd1;
			end
			2: begin
				seg = 16'hFFFF;
				limit = 32'hFFFF_FFFF;
				iw = 32'd65535;
				ith = 32'd262140;
			end
			default: begin
				seg = 16'($urandom_range(0, 1) ? $urandom_range(1, 1500)
					: $urandom_range(1, 65535));
				pick = $urandom_range(0, 3);
				if (pick == 0) limit = $urandom;
				else if (pick == 1) limit = 32'hFFFF_FFFF;
				else limit = seg * $urandom_range(4, 200);
				iw = seg * $urandom_range(1, 10);
				ith = seg * $urandom_range(2, 30);
			end
			endcase
			apply_settings(seg, limit, 1'(phase % 2), iw, ith);
			for (n = 0; n < ITEMS_PER_PHASE; n++) begin
				pick = $urandom_range(0, 99);
				if (n == 0 || pick >= 93) op = OP_RESTART;
				else if (pick < 78) op = OP_ACK;
				else if (pick < 87) op = OP_LOSS;
				else op = OP_TIMEOUT;
				case ($urandom_range(0, 3))
				0: acked = $urandom;
				1: acked = $urandom_range(0, 64);
				default: acked = $urandom_range(0, 2 * seg + 1);
				endcase
				case ($urandom_range(0, 3))
				0: flight = $urandom;
				1: flight = seg * $urandom_range(0, 40);
				2: flight = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
				default: flight = $urandom_range(0, 200000);
				endcase
				case ($urandom_range(0, 3))
				0: dups = 16'($urandom);
				1: dups = 16'hFFFF;
				default: dups = 16'($urandom_range(0, 5));
				endcase
				if (burst_left == 0) begin
					if ($urandom_range(0, 3) == 0) pause_requests($urandom_range(15, 45));
					else pause_requests($urandom_range(1, 6));
					burst_left = $urandom_range(1, 30);
				end else if ($urandom_range(0, 59) == 0) begin
					wait_drained();
				end
				send_event(op, acked, flight, dups);
				burst_left--;
			end
		end
	endtask

	always @(posedge clk) begin
		stall_phase <= stall_phase + 6'd1;
		if (stall_phase == '0) rx_pattern <= rx_pattern_t'($urandom_range(0, 3));
		if (!arst_n) begin
			res_ready <= 1'b0;
		end else begin
			case (rx_pattern)
			RX_STEADY:   res_ready <= 1'b1;
			RX_COIN:     res_ready <= 1'($urandom_range(0, 1));
			RX_PERIODIC: res_ready <= (stall_phase[2:0] == 3'd0);
			default:     res_ready <= ($urandom_range(0, 9) == 0);
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_valid === 1'b1 && res_ready) begin
			if (pending_windows.size() == 0) begin
				$error("unexpected response: window %0d threshold %0d",
					res_data.window, res_data.threshold);
				mismatches++;
			end else begin
				expected_res = pending_windows.pop_front();
				responses_checked++;
				if (res_data.window !== expected_res.window) begin
					$error("window mismatch: expected %0d, actual %0d",
						expected_res.window, res_data.window);
					mismatches++;
				end
				if (res_data.threshold !== expected_res.threshold) begin
					$error("threshold mismatch: expected %0d, actual %0d",
						expected_res.threshold, res_data.threshold);
					mismatches++;
				end
			end
		end
	end

	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((req_valid && req_ready === 1'b1) || (res_valid === 1'b1 && res_ready)) quiet = 0;
			else quiet++;
		end
		$display("congestion_window_update verification failed");
		$finish;
	end

	initial begin
		seg_size = RST_SEGMENT_SIZE;
		win_limit = RST_WINDOW_LIMIT;
		sctp_mode = RST_PROTOCOL_MODE;
		init_win = RST_INITIAL_WINDOW;
		init_thr = RST_INITIAL_THRESHOLD;
		cwnd_now = RST_INITIAL_WINDOW;
		ssthresh_now = RST_INITIAL_THRESHOLD;
		credit_now = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_values();
		test_tcp_extremes();
		test_sctp_steps();
		test_zero_sizes();
		test_random_traffic();
		wait_drained();
		$display("covered %0d requests: %0d ack, %0d loss, %0d timeout, %0d restart",
			op_seen[OP_ACK] + op_seen[OP_LOSS] + op_seen[OP_TIMEOUT] + op_seen[OP_RESTART],
			op_seen[OP_ACK], op_seen[OP_LOSS], op_seen[OP_TIMEOUT], op_seen[OP_RESTART]);
		$display("%0d register settings, %0d responses checked, %0d mismatches",
			settings_applied, responses_checked, mismatches);
		if (mismatches == 0) begin
			$display("congestion_window_update verification clean");
		end else begin
			$display("congestion_window_update verification failed");
		end
		$finish;
	end

endmodule

### congestion_window_update.f
src/cwu_pkg.sv
src/congestion_window_update.sv
sim/tb_congestion_window_update.sv
